// File: hw/rtl/n2a_pkg.sv
package n2a_pkg;

  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned NumW     = 32;
  localparam int unsigned CharW    = 7;
  localparam int unsigned PosW     = 4;
  localparam int unsigned StepW    = 2;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned CntW     = 3;
  // wide enough for 8 * 10^9
  localparam int unsigned WeightW  = 33;

  localparam logic [ReqTypeW-1:0] ReqDec   = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqHex8  = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqHex16 = 2'd2;
  localparam logic [ReqTypeW-1:0] ReqHex32 = 2'd3;

  localparam logic [PosW-1:0]  PosTop   = 4'd9;
  localparam logic [StepW-1:0] StepLast = 2'd3;

  typedef struct packed {
    logic            take;
    logic [NumW-1:0] rest;
  } n2a_cmp_t;

  // 10^pos scaled by the binary weight 8, 4, 2, 1 of the step
  function automatic logic [WeightW-1:0] pow10_weight(input logic [PosW-1:0]  pos,
                                                      input logic [StepW-1:0] step);
    logic [WeightW-1:0] p;
    case (pos)
      4'd0:    p = 33'd1;
      4'd1:    p = 33'd10;
      4'd2:    p = 33'd100;
      4'd3:    p = 33'd1000;
      4'd4:    p = 33'd10000;
      4'd5:    p = 33'd100000;
      4'd6:    p = 33'd1000000;
      4'd7:    p = 33'd10000000;
      4'd8:    p = 33'd100000000;
      4'd9:    p = 33'd1000000000;
      default: p = '0;
    endcase
    return p << (StepLast - step);
  endfunction

  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + {3'b000, nib};
    end else begin
      return 7'h37 + {3'b000, nib};
    end
  endfunction

endpackage

// File: hw/rtl/n2a_if.sv
interface n2a_req_if import n2a_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [NumW-1:0]     number_in;

  modport source (output valid, req_type, number_in, input ready);
  modport sink   (input valid, req_type, number_in, output ready);
endinterface

interface n2a_char_if import n2a_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] ascii_char;
  logic             last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

// File: hw/rtl/number_to_ascii_formatter_unit.sv
// Channel  Dir  Payload                         Beat
// req_i    in   req_type[1:0], number_in[31:0]  one number to format
// char_o   out  ascii_char[6:0], last_char      one character, MSB first
//
// Decimal works through each power of ten with the weights 8, 4, 2, 1
// through one shared compare-subtract unit.
// Hex emits 2, 4 or 8 digits, each one waiting while the output register is full.
// req_i is ready only between numbers; a full output register stalls the sequencer.
// Reset clears the sequencer and the output valid flag.
module number_to_ascii_formatter_unit import n2a_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  n2a_req_if.sink      req_i,
  n2a_char_if.source   char_o
);

  typedef enum logic [1:0] {StIdle, StDec, StHex} state_e;

  state_e            state_q;
  logic [NumW-1:0]   val_q;
  logic [PosW-1:0]   pos_q;
  logic [StepW-1:0]  step_q;
  logic [DigitW-1:0] digit_q;
  logic              started_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;

  n2a_cmp_t          cmp;
  logic              can_push;
  logic [DigitW-1:0] bit_w;
  logic [DigitW-1:0] digit_full;
  logic              dec_emit;
  logic              char_push;

  n2a_cmp_sub u_cmp_sub (
    .val_i  (val_q),
    .pos_i  (pos_q),
    .step_i (step_q),
    .cmp_o  (cmp)
  );

  always_comb begin
    can_push   = !out_valid_q || char_o.ready;
    bit_w      = 4'b1000 >> step_q;
    digit_full = digit_q | (cmp.take ? bit_w : '0);
    dec_emit   = (digit_full != '0) || started_q || (pos_q == '0);
    // a new character enters the output register this cycle
    char_push  = ((state_q == StDec) && (step_q == StepLast) && dec_emit && can_push) ||
                 ((state_q == StHex) && can_push);
  end

  assign req_i.ready       = (state_q == StIdle);
  assign char_o.valid      = out_valid_q;
  assign char_o.ascii_char = out_char_q;
  assign char_o.last_char  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      val_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      digit_q     <= '0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && char_o.ready && !char_push) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            pos_q     <= PosTop;
            step_q    <= '0;
            digit_q   <= '0;
            started_q <= 1'b0;
            case (req_i.req_type)
              ReqDec: begin
                val_q   <= req_i.number_in;
                state_q <= StDec;
              end
              ReqHex8: begin
                val_q   <= req_i.number_in << 24;
                cnt_q   <= 3'd1;
                state_q <= StHex;
              end
              ReqHex16: begin
                val_q   <= req_i.number_in << 16;
                cnt_q   <= 3'd3;
                state_q <= StHex;
              end
              default: begin
                val_q   <= req_i.number_in;
                cnt_q   <= 3'd7;
                state_q <= StHex;
              end
            endcase
          end
        end
        StDec: begin
          // hold the whole step while the finished digit cannot leave
          if (!(step_q == StepLast && dec_emit && !can_push)) begin
            if (cmp.take) begin
              val_q <= cmp.rest;
            end
            if (step_q == StepLast) begin
              step_q  <= '0;
              digit_q <= '0;
              if (dec_emit) begin
                out_valid_q <= 1'b1;
                out_char_q  <= glyph(digit_full);
                out_last_q  <= (pos_q == '0);
                started_q   <= 1'b1;
              end
              if (pos_q == '0) begin
                state_q <= StIdle;
              end else begin
                pos_q <= pos_q - 4'd1;
              end
            end else begin
              step_q  <= step_q + 2'd1;
              digit_q <= digit_full;
            end
          end
        end
        StHex: begin
          if (can_push) begin
            out_valid_q <= 1'b1;
            out_char_q  <= glyph(val_q[NumW-1 -: DigitW]);
            out_last_q  <= (cnt_q == '0);
            val_q       <= val_q << DigitW;
            if (cnt_q == '0) begin
              state_q <= StIdle;
            end else begin
              cnt_q <= cnt_q - 3'd1;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/n2a_cmp_sub.sv
module n2a_cmp_sub import n2a_pkg::*; (
  input  logic [NumW-1:0]  val_i,
  input  logic [PosW-1:0]  pos_i,
  input  logic [StepW-1:0] step_i,
  output n2a_cmp_t         cmp_o
);

  logic [WeightW-1:0] weight;

  always_comb begin
    weight     = pow10_weight(pos_i, step_i);
    cmp_o.take = {{(WeightW-NumW){1'b0}}, val_i} >= weight;
    cmp_o.rest = val_i - weight[NumW-1:0];
  end

endmodule
